// ----- rtl/brt_pkg.sv -----
package brt_pkg;

  // Ticks per second of the relay timeout
  localparam int unsigned TICKS_PER_SEC = 1000;

  // Field and counter widths
  localparam int unsigned DUR_W    = 17;
  localparam int unsigned DEB_W    = 10;
  localparam int unsigned BLINK_W  = 16;
  localparam int unsigned RELAY_W  = 27;
  localparam int unsigned BCNT_W   = 17;
  localparam int unsigned CFG_IDX_W = 2;
  localparam int unsigned CFG_DAT_W = 17;

  // Register reset values
  localparam logic [DUR_W-1:0]   DUR_RST       = DUR_W'(60);
  localparam logic [DEB_W-1:0]   DEB_RST       = DEB_W'(100);
  localparam logic [BLINK_W-1:0] BLINK_ON_RST  = BLINK_W'(500);
  localparam logic [BLINK_W-1:0] BLINK_OFF_RST = BLINK_W'(500);
  localparam logic [RELAY_W-1:0] TIMEOUT_RST   = RELAY_W'(60 * TICKS_PER_SEC);

  // Configuration register indexes
  typedef enum logic [CFG_IDX_W-1:0] {
    CFG_DURATION  = 2'd0,
    CFG_DEBOUNCE  = 2'd1,
    CFG_BLINK_ON  = 2'd2,
    CFG_BLINK_OFF = 2'd3
  } cfg_idx_t;

  // LED drive mode
  typedef enum logic [1:0] {
    LED_OFF   = 2'd0,
    LED_ON    = 2'd1,
    LED_FLASH = 2'd2
  } led_mode_t;

  // One result word
  typedef struct packed {
    logic relay_on;
    logic led_lit;
    logic press_seen;
  } res_t;

endpackage

// ----- rtl/brt_core.sv -----
module brt_core
  import brt_pkg::*;
(
  input  logic                 clk,
  input  logic                 rst_n,
  input  logic                 cfg_we,
  input  logic [CFG_IDX_W-1:0] cfg_index,
  input  logic [CFG_DAT_W-1:0] cfg_wdata,
  input  logic                 tick,
  input  logic                 level,
  output res_t                 res
);

  // Configuration
  logic [RELAY_W-1:0] timeout_r;
  logic [DEB_W-1:0]   debounce_ms_r;
  logic [BLINK_W-1:0] blink_on_r;
  logic [BLINK_W-1:0] blink_off_r;

  // Tick state
  logic               last_level_r, last_level_nxt;
  logic               armed_r, armed_nxt;
  logic [DEB_W-1:0]   deb_r, deb_nxt;
  logic               relay_closed_r, relay_closed_nxt;
  logic [RELAY_W-1:0] relay_el_r, relay_el_nxt;
  led_mode_t          led_mode_r, led_mode_nxt;
  logic               led_val_r, led_val_nxt;
  logic [BCNT_W-1:0]  blink_r, blink_nxt;
  logic               press;

  // Saturating counters
  logic [DEB_W-1:0]   deb_inc;
  logic [RELAY_W-1:0] relay_inc;
  logic [BCNT_W-1:0]  blink_inc;

  assign deb_inc   = (&deb_r)      ? deb_r      : deb_r + 1'b1;
  assign relay_inc = (&relay_el_r) ? relay_el_r : relay_el_r + 1'b1;
  assign blink_inc = (&blink_r)    ? blink_r    : blink_r + 1'b1;

  // Config writes; the timeout product is registered at write time
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      timeout_r     <= TIMEOUT_RST;
      debounce_ms_r <= DEB_RST;
      blink_on_r    <= BLINK_ON_RST;
      blink_off_r   <= BLINK_OFF_RST;
    end else if (cfg_we) begin
      case (cfg_idx_t'(cfg_index))
        CFG_DURATION:  timeout_r <= RELAY_W'(RELAY_W'(cfg_wdata[DUR_W-1:0]) *
                                            RELAY_W'(TICKS_PER_SEC));
        CFG_DEBOUNCE:  debounce_ms_r <= cfg_wdata[DEB_W-1:0];
        CFG_BLINK_ON:  blink_on_r    <= cfg_wdata[BLINK_W-1:0];
        CFG_BLINK_OFF: blink_off_r   <= cfg_wdata[BLINK_W-1:0];
        default: ;
      endcase
    end
  end

  // Debounce, press toggle and relay timeout
  always_comb begin
    logic               armed1;
    logic [DEB_W-1:0]   deb1;
    logic               closed1;
    logic [RELAY_W-1:0] rel1;
    led_mode_t          mode1;
    armed1 = armed_r;
    deb1   = deb_inc;
    if (level != last_level_r) begin
      deb1   = '0;
      armed1 = ~level;
    end
    last_level_nxt = level;
    press     = 1'b0;
    armed_nxt = armed1;
    deb_nxt   = deb1;
    if (deb1 > debounce_ms_r) begin
      deb_nxt = '0;
      if (!level && armed1) begin
        press     = 1'b1;
        armed_nxt = 1'b0;
      end
    end
    closed1 = relay_closed_r;
    rel1    = relay_inc;
    mode1   = led_mode_r;
    if (press) begin
      if (relay_closed_r) begin
        closed1 = 1'b0;
        mode1   = LED_FLASH;
      end else begin
        closed1 = 1'b1;
        mode1   = LED_ON;
        rel1    = '0;
      end
    end
    relay_el_nxt     = rel1;
    relay_closed_nxt = closed1;
    led_mode_nxt     = mode1;
    // an open relay always counts as expired
    if (!closed1 || rel1 >= timeout_r) begin
      relay_closed_nxt = 1'b0;
      led_mode_nxt     = LED_FLASH;
    end
  end

  // LED drive from the new mode
  always_comb begin
    led_val_nxt = led_val_r;
    blink_nxt   = blink_inc;
    case (led_mode_nxt)
      LED_ON: led_val_nxt = 1'b1;
      LED_FLASH: begin
        if (led_val_r && blink_inc > {1'b0, blink_on_r}) begin
          blink_nxt   = '0;
          led_val_nxt = 1'b0;
        end else if (!led_val_r && blink_inc > {1'b0, blink_off_r}) begin
          blink_nxt   = '0;
          led_val_nxt = 1'b1;
        end
      end
      default: led_val_nxt = 1'b0;
    endcase
  end

  assign res.relay_on   = relay_closed_nxt;
  assign res.led_lit    = led_val_nxt;
  assign res.press_seen = press;

  // State update once per accepted tick
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      last_level_r   <= 1'b0;
      armed_r        <= 1'b0;
      deb_r          <= '0;
      relay_closed_r <= 1'b0;
      relay_el_r     <= '0;
      led_mode_r     <= LED_OFF;
      led_val_r      <= 1'b0;
      blink_r        <= '0;
    end else if (tick) begin
      last_level_r   <= last_level_nxt;
      armed_r        <= armed_nxt;
      deb_r          <= deb_nxt;
      relay_closed_r <= relay_closed_nxt;
      relay_el_r     <= relay_el_nxt;
      led_mode_r     <= led_mode_nxt;
      led_val_r      <= led_val_nxt;
      blink_r        <= blink_nxt;
    end
  end

`ifndef SYNTHESIS
  // a closed relay always shows the LED steady on
  a_closed_led_on: assert property (@(posedge clk) disable iff (!rst_n)
    relay_closed_r |-> led_mode_r == LED_ON)
    else $error("relay closed without steady LED");

  // after any tick an open relay means blink mode
  a_open_blink: assert property (@(posedge clk) disable iff (!rst_n)
    tick |=> (relay_closed_r || led_mode_r == LED_FLASH))
    else $error("open relay not blinking");

  // a counted press restarts the debounce count and disarms
  a_press_restart: assert property (@(posedge clk) disable iff (!rst_n)
    (tick && press) |=> (deb_r == '0 && !armed_r))
    else $error("press did not restart debounce");
`endif

endmodule

// ----- rtl/brt_outq.sv -----
module brt_outq
  import brt_pkg::*;
(
  input  logic clk,
  input  logic rst_n,
  input  logic push,
  input  res_t push_word,
  output logic full,
  output logic pop_valid,
  input  logic pop_stall,
  output res_t pop_word
);

  // Two-entry result queue so a tick is taken while a word waits
  res_t       mem_r [2];
  logic       wr_ptr_r, rd_ptr_r;
  logic [1:0] count_r;
  logic       pop;

  assign full      = count_r[1];
  assign pop_valid = (count_r != 2'd0);
  assign pop       = pop_valid && !pop_stall;
  assign pop_word  = mem_r[rd_ptr_r];

  always_ff @(posedge clk) begin
    if (push) begin
      mem_r[wr_ptr_r] <= push_word;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= 1'b0;
      rd_ptr_r <= 1'b0;
      count_r  <= 2'd0;
    end else begin
      if (push) wr_ptr_r <= ~wr_ptr_r;
      if (pop)  rd_ptr_r <= ~rd_ptr_r;
      case ({push, pop})
        2'b10:   count_r <= count_r + 2'd1;
        2'b01:   count_r <= count_r - 2'd1;
        default: count_r <= count_r;
      endcase
    end
  end

`ifndef SYNTHESIS
  // never pushed while full
  a_no_overflow: assert property (@(posedge clk) disable iff (!rst_n)
    full |-> !push)
    else $error("push into full queue");

  // occupancy stays within two words
  a_count_range: assert property (@(posedge clk) disable iff (!rst_n)
    count_r != 2'd3)
    else $error("queue count out of range");

  // pointers agree with occupancy when empty or full
  a_ptr_match: assert property (@(posedge clk) disable iff (!rst_n)
    (count_r == 2'd0 || count_r == 2'd2) |-> wr_ptr_r == rd_ptr_r)
    else $error("queue pointers out of step");
`endif

endmodule

// ----- rtl/button_toggled_relay_timer.sv -----
// Channel   Direction  Handshake           Word
// in_       input      in_valid/in_stall   in_button_level
// out_      output     out_valid/out_stall out_relay_on, out_led_lit, out_press_seen
// cfg_      input      cfg_we              cfg_index, cfg_wdata
//
// One tick is taken per cycle while in_stall is low; its result is ready in
// the output queue the next cycle, and one word leaves per cycle while out_stall is low.
// A two-word output queue lets a tick enter while a result waits; in_stall
// rises only when both words are held by out_stall.
// Synchronous active-low reset loads register defaults and clears all state but the queue's word storage.
module button_toggled_relay_timer
  import brt_pkg::*;
(
  input  logic                 clk,
  input  logic                 rst_n,
  input  logic                 in_valid,
  output logic                 in_stall,
  input  logic                 in_button_level,
  output logic                 out_valid,
  input  logic                 out_stall,
  output logic                 out_relay_on,
  output logic                 out_led_lit,
  output logic                 out_press_seen,
  input  logic                 cfg_we,
  input  logic [CFG_IDX_W-1:0] cfg_index,
  input  logic [CFG_DAT_W-1:0] cfg_wdata
);

  logic tick;
  logic full;
  res_t res;
  res_t q_word;

  assign in_stall = full;
  assign tick     = in_valid && !full;

  // tick logic and state
  brt_core u_core (
    .clk       (clk),
    .rst_n     (rst_n),
    .cfg_we    (cfg_we),
    .cfg_index (cfg_index),
    .cfg_wdata (cfg_wdata),
    .tick      (tick),
    .level     (in_button_level),
    .res       (res)
  );

  // result queue
  brt_outq u_outq (
    .clk       (clk),
    .rst_n     (rst_n),
    .push      (tick),
    .push_word (res),
    .full      (full),
    .pop_valid (out_valid),
    .pop_stall (out_stall),
    .pop_word  (q_word)
  );

  assign out_relay_on   = q_word.relay_on;
  assign out_led_lit    = q_word.led_lit;
  assign out_press_seen = q_word.press_seen;

endmodule
